>>> rtl/fbcdu_pkg.sv
// Package for the five-bit code dictionary unpacker.
// Holds the item types, the kind codes and the sizes shared by all modules.
// Depends on nothing.
`default_nettype none

package fbcdu_pkg;

   localparam int CODE_BITS     = 5;
   localparam int DICT_SIZE     = 31;
   localparam int DICT_INDEX_W  = $clog2(DICT_SIZE);
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W   = $clog2(RSP_QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [CODE_BITS-1:0] END_CODE = CODE_BITS'(31);

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DICT  = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        data_byte;
      logic [4:0]        entry_index;
      logic [7:0]        entry_value;
   } req_type;

   typedef struct packed {
      logic [7:0] char_value;
      logic       end_marker;
      logic       last;
   } rsp_type;

   // Up to two results enter the result queue together.
   typedef struct packed {
      logic [1:0] n;
      rsp_type    first;
      rsp_type    second;
   } rsp_push_type;

endpackage

`default_nettype wire

>>> rtl/fbcdu_dict.sv
// Character dictionary of the five-bit code unpacker: one write port and two
// registered read ports. Depends on fbcdu_pkg.
`default_nettype none

module fbcdu_dict
   import fbcdu_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [DICT_INDEX_W-1:0] wr_index,
   input  wire logic [7:0]              wr_value,
   input  wire logic [DICT_INDEX_W-1:0] rd_index_0,
   input  wire logic [DICT_INDEX_W-1:0] rd_index_1,
   output logic      [7:0]              rd_value_0,
   output logic      [7:0]              rd_value_1
);

   logic [7:0] dict_ff [DICT_SIZE];
   logic [7:0] rd_value_0_ff;
   logic [7:0] rd_value_1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dict_ff[wr_index] <= wr_value;
      end
   end

   // The terminator code also arrives here as an address; its data is never used.
   always_ff @(posedge clock) begin
      rd_value_0_ff <= dict_ff[rd_index_0];
      rd_value_1_ff <= dict_ff[rd_index_1];
   end

   assign rd_value_0 = rd_value_0_ff;
   assign rd_value_1 = rd_value_1_ff;

endmodule

`default_nettype wire

>>> rtl/fbcdu_rsp_queue.sv
// Result queue of the five-bit code unpacker: takes up to two items at
// once, hands out one item per cycle unless stalled. Depends on fbcdu_pkg.
`default_nettype none

module fbcdu_rsp_queue
   import fbcdu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rsp_push_type             push,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_payload,
   output logic      [QUEUE_LEVEL_W-1:0] level
);

   rsp_type                  q_ff [RSP_QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_W-1:0] count_ff, count_in;
   logic                     pop;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_next;

   assign pop         = (count_ff != '0) && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.n);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_LEVEL_W'(push.n) - QUEUE_LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.n == 2'd2) begin
         q_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = q_ff[rd_ptr_ff];
   assign level       = count_ff;

   a_push_count_legal: assert property (@(posedge clock) disable iff (reset)
      push.n != 2'd3)
      else $error("result queue push of more than two items");

   a_empty_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("result queue empty but pointers differ");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_LEVEL_W'(RSP_QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

`default_nettype wire

>>> rtl/five_bit_code_dictionary_unpacker.sv
// Five-bit code dictionary unpacker, top level.
// Input items on req_* are data bytes, dictionary writes or stream starts.
// Data bytes are split most significant bit first into five-bit codes; each
// code below 31 selects a character from the 31-entry dictionary, and code
// 31 gives an end marker, after which data is ignored until a start item.
// Results leave on rsp_* one item per cycle while rsp_stall is low; last
// marks the final result of an input item. Dictionary writes and start
// items give no result. An item is taken at any edge with valid high and
// stall low on its channel. The first result of a data byte passes the
// dictionary read register and then the result queue before it is offered.
// Throughput: one input item per cycle while req_stall is low; a byte that
// yields two characters puts two results on the result channel, so such
// streams back up the input. The four-entry result queue sets how far
// input can run ahead: req_stall rises when the queue and the stage feeding
// it could not take two more results, and depends on registers only.
// Reset clears the bit buffer, byte phase, end flag and result queue; the
// dictionary keeps its contents and must be written before it is read.
// A stalled receiver holds its result in the queue and input backs up.
// Depends on fbcdu_pkg, fbcdu_dict and fbcdu_rsp_queue.
`default_nettype none

module five_bit_code_dictionary_unpacker
   import fbcdu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic                     req_accept;
   logic                     data_live;
   logic                     dict_wr_en;
   logic [2:0]               have_bits;
   logic [3:0]               bit_count;
   logic [11:0]              acc;
   logic [3:0]               shift_0;
   logic [3:0]               shift_1;
   logic [3:0]               rem_bits;
   logic [CODE_BITS-1:0]     code_0;
   logic [CODE_BITS-1:0]     code_1;
   logic                     two_codes;
   logic                     end_0;
   logic                     end_1;

   logic [3:0]               leftover_ff, leftover_in;
   logic [2:0]               phase_ff, phase_in;
   logic                     done_ff, done_in;
   logic [1:0]               s1_n_ff, s1_n_in;
   logic                     s1_end_0_ff, s1_end_0_in;
   logic                     s1_end_1_ff, s1_end_1_in;

   logic [7:0]               rd_value_0;
   logic [7:0]               rd_value_1;
   rsp_push_type             push;
   logic [QUEUE_LEVEL_W-1:0] queue_level;
   logic [QUEUE_LEVEL_W:0]   queue_demand;

   assign req_accept = req_valid && !req_stall;
   assign data_live  = req_accept && (req_payload.kind == KIND_DATA) && !done_ff;
   assign dict_wr_en = req_accept && (req_payload.kind == KIND_DICT) &&
                       (req_payload.entry_index <= DICT_INDEX_W'(DICT_SIZE - 1));

   // Bits still held from earlier bytes, by byte position within five bytes.
   always_comb begin
      case (phase_ff)
         3'd0:    have_bits = 3'd0;
         3'd1:    have_bits = 3'd3;
         3'd2:    have_bits = 3'd1;
         3'd3:    have_bits = 3'd4;
         3'd4:    have_bits = 3'd2;
         default: have_bits = 3'd0;
      endcase
   end

   always_comb begin
      acc       = {leftover_ff, req_payload.data_byte};
      bit_count = 4'(have_bits) + 4'd8;
      two_codes = bit_count >= 4'(2 * CODE_BITS);
      shift_0   = bit_count - 4'(CODE_BITS);
      shift_1   = bit_count - 4'(2 * CODE_BITS);
      code_0    = CODE_BITS'(acc >> shift_0);
      code_1    = CODE_BITS'(acc >> shift_1);
      end_0     = (code_0 == END_CODE);
      end_1     = two_codes && !end_0 && (code_1 == END_CODE);
      rem_bits  = two_codes ? shift_1 : shift_0;
   end

   // Stream state and the stage that waits for the dictionary read.
   always_comb begin
      leftover_in = leftover_ff;
      phase_in    = phase_ff;
      done_in     = done_ff;
      s1_n_in     = 2'd0;
      s1_end_0_in = 1'b0;
      s1_end_1_in = 1'b0;
      if (req_accept) begin
         case (req_payload.kind)
            KIND_START: begin
               leftover_in = 4'd0;
               phase_in    = 3'd0;
               done_in     = 1'b0;
            end
            KIND_DATA: begin
               if (!done_ff) begin
                  s1_end_0_in = end_0;
                  s1_end_1_in = end_1;
                  s1_n_in     = (two_codes && !end_0) ? 2'd2 : 2'd1;
                  if (end_0 || end_1) begin
                     leftover_in = 4'd0;
                     done_in     = 1'b1;
                  end else begin
                     leftover_in = 4'(acc & ((12'd1 << rem_bits) - 12'd1));
                     phase_in    = (phase_ff == 3'(CODE_BITS - 1)) ? 3'd0
                                                                 : phase_ff + 3'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= '0;
         phase_ff    <= '0;
         done_ff     <= 1'b0;
         s1_n_ff     <= '0;
         s1_end_0_ff <= 1'b0;
         s1_end_1_ff <= 1'b0;
      end else begin
         leftover_ff <= leftover_in;
         phase_ff    <= phase_in;
         done_ff     <= done_in;
         s1_n_ff     <= s1_n_in;
         s1_end_0_ff <= s1_end_0_in;
         s1_end_1_ff <= s1_end_1_in;
      end
   end

   fbcdu_dict u_dict (
      .clock      (clock),
      .wr_en      (dict_wr_en),
      .wr_index   (req_payload.entry_index),
      .wr_value   (req_payload.entry_value),
      .rd_index_0 (code_0),
      .rd_index_1 (code_1),
      .rd_value_0 (rd_value_0),
      .rd_value_1 (rd_value_1)
   );

   always_comb begin
      push.n                 = s1_n_ff;
      push.first.char_value  = s1_end_0_ff ? 8'd0 : rd_value_0;
      push.first.end_marker  = s1_end_0_ff;
      push.first.last        = (s1_n_ff == 2'd1);
      push.second.char_value = s1_end_1_ff ? 8'd0 : rd_value_1;
      push.second.end_marker = s1_end_1_ff;
      push.second.last       = 1'b1;
   end

   fbcdu_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .level       (queue_level)
   );

   // Room must remain for the item in flight plus two results of a new one.
   assign queue_demand = (QUEUE_LEVEL_W + 1)'(queue_level) + (QUEUE_LEVEL_W + 1)'(s1_n_ff);
   assign req_stall    = queue_demand > (QUEUE_LEVEL_W + 1)'(RSP_QUEUE_DEPTH - 2);

   a_data_gives_result: assert property (@(posedge clock) disable iff (reset)
      data_live |=> (s1_n_ff != 2'd0))
      else $error("live data item produced no result");

   a_done_clears_buffer: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (leftover_ff == 4'd0))
      else $error("bit buffer not empty after end of stream");

   a_end_first_alone: assert property (@(posedge clock) disable iff (reset)
      s1_end_0_ff |-> (s1_n_ff == 2'd1))
      else $error("result follows an end marker");

   a_end_second_pair: assert property (@(posedge clock) disable iff (reset)
      s1_end_1_ff |-> (s1_n_ff == 2'd2))
      else $error("second end marker without first result");

endmodule

`default_nettype wire
